### hdl/odometry_braking_stop_controller_core_macros.svh
// Assertion macros for the odometry braking stop controller.
// Used by the core; standalone, no other dependencies.
`ifndef ODOMETRY_BRAKING_STOP_CONTROLLER_CORE_MACROS_SVH
`define ODOMETRY_BRAKING_STOP_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define OBSC_ASSERT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// next-cycle implication
`define OBSC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`else
`define OBSC_ASSERT(lbl, clk_s, rst_s, ante, cons)
`define OBSC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

### hdl/obsc_pkg.sv
// Shared types and constants for the odometry braking stop controller.
// No dependencies.
`timescale 1ns / 1ps

package obsc_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned RATE_W    = 8;
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned RAD_W     = 66;           // radicand, even width
  localparam int unsigned ROOT_W    = RAD_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned SQ_STEPS  = ROOT_W;
  localparam int unsigned SQ_CNT_W  = $clog2(SQ_STEPS);
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 168;        // 161 bits used

  localparam logic [DATA_W-1:0] U32_MAX = '1;

  // register reset values
  localparam logic [DATA_W-1:0] RST_TARGET   = 32'd65536;
  localparam logic [RATE_W-1:0] RST_RATE     = 8'd10;
  localparam logic [DATA_W-1:0] RST_COEF_SQ  = 32'd114445;
  localparam logic [DATA_W-1:0] RST_COEF_LIN = 32'd8408;
  localparam logic [DATA_W-1:0] RST_OFFSET   = 32'd1389;
  localparam logic [DATA_W-1:0] RST_LIMIT    = 32'd49152;
  localparam logic [DATA_W-1:0] RST_CAP      = 32'd75366;
  localparam logic [DATA_W-1:0] RST_CRUISE   = 32'd32768;

  typedef enum logic [2:0] {
    REG_TARGET   = 3'd0,
    REG_RATE     = 3'd1,
    REG_COEF_SQ  = 3'd2,
    REG_COEF_LIN = 3'd3,
    REG_OFFSET   = 3'd4,
    REG_LIMIT    = 3'd5,
    REG_CAP      = 3'd6,
    REG_CRUISE   = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DX,
    S_DY,
    S_SUMSQ,
    S_SQRT,
    S_RATE,
    S_SPD,
    S_BRK,
    S_T1L,
    S_T1H,
    S_LIN,
    S_SUM,
    S_STOP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        origin_sample;
    logic        stopped;
    logic [31:0] drive_command;
    logic [31:0] braking_distance;
    logic [31:0] speed;
    logic [31:0] rel_y;
    logic [31:0] rel_x;
  } result_t;

endpackage

### hdl/obsc_mul.sv
// Shared 32x32 unsigned multiplier with registered product.
// Depends on obsc_pkg.
`timescale 1ns / 1ps

module obsc_mul
  import obsc_pkg::*;
(
  input  logic              clk,
  input  logic [DATA_W-1:0] op_a,
  input  logic [DATA_W-1:0] op_b,
  output logic [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

### hdl/obsc_sqrt.sv
// Iterative floor square root, one result bit per cycle.
// Depends on obsc_pkg.
`timescale 1ns / 1ps

module obsc_sqrt
  import obsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  rad,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  logic                busy;
  logic [SQ_CNT_W-1:0] cnt;
  logic [RAD_W-1:0]    rad_sh;
  logic [REM_W-1:0]    rem;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                ge;

  // bring down the next pair, trial = 4*root + 1
  always_comb begin
    rem_sh = {rem, rad_sh[RAD_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == SQ_CNT_W'(SQ_STEPS - 1))) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= rad;
      rem    <= '0;
      root   <= '0;
      cnt    <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[RAD_W-3:0], 2'b00};
      rem    <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root   <= {root[ROOT_W-2:0], ge};
      cnt    <= cnt + 1'b1;
    end
  end

endmodule

### hdl/odometry_braking_stop_controller_core.sv
// Top level of the odometry braking stop controller: sequencer, registers,
// config port. Depends on obsc_pkg, obsc_mul, obsc_sqrt and the macro header.
`timescale 1ns / 1ps
`include "odometry_braking_stop_controller_core_macros.svh"

// Usage
//  - Input stream s_*: one pose word per sample, x in bits 31:0, y in 63:32,
//    signed Q16.16. The first word after reset becomes the origin.
//  - Output stream m_*: one result word per input word, in order.
//  - Config: cfg_we/cfg_addr/cfg_wdata write one register per cycle; write
//    only while idle (no word in flight).
//  - Sequence: a later word runs the 33-step square root (one root bit per
//    cycle) and seven passes through the single shared 32x32 multiplier,
//    each registered; over the speed limit the braking-term passes are
//    skipped, and an origin word goes straight to the braking passes.
//  - Flow: one word at a time; s_tready is high only while the
//    sequencer is idle.
//  - Output stall: the result sits in an output register. The next word is
//    accepted and worked on meanwhile; it waits in its last state until the
//    register is taken.
//  - Reset (rst, synchronous): registers back to defaults, origin forgotten,
//    stop latch cleared, output empty.
//  - Once stopped, drive_command stays zero until reset.
module odometry_braking_stop_controller_core
  import obsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // pose_x[31:0], pose_y[63:32]
  // output stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // rel_x[31:0], rel_y[63:32], speed[95:64], braking_distance[127:96],
  // drive_command[159:128], stopped[160], zero pad [167:161]
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tuser,   // origin_sample[0]
  // config write port
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_addr,
  input  logic [DATA_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [DATA_W-1:0] target_distance;
  logic [RATE_W-1:0] sample_rate;
  logic [DATA_W-1:0] brake_coef_sq;
  logic [DATA_W-1:0] brake_coef_lin;
  logic [DATA_W-1:0] brake_offset;
  logic [DATA_W-1:0] speed_limit;
  logic [DATA_W-1:0] brake_cap;
  logic [DATA_W-1:0] cruise_speed;

  // persistent state
  logic [DATA_W-1:0] origin_x, origin_y;
  logic [DATA_W-1:0] prev_rel_x, prev_rel_y;
  logic [DATA_W-1:0] last_speed;
  logic              origin_taken;
  logic              stop_latched;

  // per-word working registers
  logic [DATA_W-1:0] rel_x, rel_y;
  logic              is_origin;
  logic [DATA_W-1:0] ay_mag;
  logic [PROD_W-1:0] sq_a;
  logic [15:0]       sq_hi;       // bits 63:48 of v*v
  logic [PROD_W-17:0] pl;         // (coef_sq * low part of v^2>>16) >> 16
  logic [DATA_W-1:0] t1;
  logic [DATA_W-1:0] brake_dist;

  state_t state, state_next;

  // output register
  result_t out_word;
  logic    out_valid;

  // shared units
  logic [DATA_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic              sqrt_start, sqrt_done;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W-1:0] root;

  obsc_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  obsc_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (rad),
    .done  (sqrt_done),
    .root  (root)
  );

  // datapath helpers
  logic              accept;
  logic              out_free;
  logic [DATA_W:0]   dx, dy;       // 33-bit signed step
  logic [DATA_W-1:0] ax_full, ay_full;  // |step| fits 32 bits
  logic [DATA_W-1:0] spd_sat;
  logic [64:0]       t1_sum;
  logic [DATA_W-1:0] t2;
  logic [33:0]       dist_sum;
  logic [33:0]       stop_lhs;
  logic              stop_hit;

  assign accept   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == S_IDLE);

  always_comb begin
    dx      = {rel_x[DATA_W-1], rel_x} - {prev_rel_x[DATA_W-1], prev_rel_x};
    dy      = {rel_y[DATA_W-1], rel_y} - {prev_rel_y[DATA_W-1], prev_rel_y};
    ax_full = dx[DATA_W] ? DATA_W'((DATA_W+1)'(0) - dx) : dx[DATA_W-1:0];
    ay_full = dy[DATA_W] ? DATA_W'((DATA_W+1)'(0) - dy) : dy[DATA_W-1:0];
    // |step| < 2^32, so each square fits 64 bits and the sum 65
    rad     = RAD_W'(sq_a) + RAD_W'(prod);

    // speed = root * rate, saturated; a 33-bit root already overflows
    if (root[ROOT_W-1]) begin
      spd_sat = (sample_rate == '0) ? '0 : U32_MAX;
    end else begin
      spd_sat = (prod[PROD_W-1:DATA_W] != '0) ? U32_MAX : prod[DATA_W-1:0];
    end

    // t1 = (coef_sq * (pl_part + ph_part<<32)) >> 16, prod holds ph here
    t1_sum = 65'(pl) + {1'b0, prod[47:0], 16'b0};
    t2     = (prod[PROD_W-1:48] != '0) ? U32_MAX : prod[47:16];
    dist_sum = 34'(t1) + 34'(t2) + 34'(brake_offset);

    stop_lhs = {{2{rel_x[DATA_W-1]}}, rel_x} + {2'b00, brake_dist};
    stop_hit = ($signed(stop_lhs) >= $signed({2'b00, target_distance}));
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_DX:    begin mul_a = ax_full;             mul_b = ax_full;             end
      S_DY:    begin mul_a = ay_mag;              mul_b = ay_mag;              end
      S_RATE:  begin mul_a = root[DATA_W-1:0];    mul_b = DATA_W'(sample_rate); end
      S_BRK:   begin mul_a = last_speed;          mul_b = last_speed;          end
      S_T1L:   begin mul_a = brake_coef_sq;       mul_b = prod[47:16];         end
      S_T1H:   begin mul_a = brake_coef_sq;       mul_b = DATA_W'(sq_hi);      end
      S_LIN:   begin mul_a = brake_coef_lin;      mul_b = last_speed;          end
      default: begin mul_a = '0;                  mul_b = '0;                  end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    sqrt_start = 1'b0;
    unique case (state)
      S_IDLE:  if (s_tvalid) state_next = origin_taken ? S_DX : S_BRK;
      S_DX:    state_next = S_DY;
      S_DY:    state_next = S_SUMSQ;
      S_SUMSQ: begin
        sqrt_start = 1'b1;
        state_next = S_SQRT;
      end
      S_SQRT:  if (sqrt_done) state_next = S_RATE;
      S_RATE:  state_next = S_SPD;
      S_SPD:   state_next = S_BRK;
      S_BRK:   state_next = (last_speed > speed_limit) ? S_STOP : S_T1L;
      S_T1L:   state_next = S_T1H;
      S_T1H:   state_next = S_LIN;
      S_LIN:   state_next = S_SUM;
      S_SUM:   state_next = S_STOP;
      S_STOP:  state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance <= RST_TARGET;
      sample_rate     <= RST_RATE;
      brake_coef_sq   <= RST_COEF_SQ;
      brake_coef_lin  <= RST_COEF_LIN;
      brake_offset    <= RST_OFFSET;
      speed_limit     <= RST_LIMIT;
      brake_cap       <= RST_CAP;
      cruise_speed    <= RST_CRUISE;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        REG_TARGET:   target_distance <= cfg_wdata;
        REG_RATE:     sample_rate     <= cfg_wdata[RATE_W-1:0];
        REG_COEF_SQ:  brake_coef_sq   <= cfg_wdata;
        REG_COEF_LIN: brake_coef_lin  <= cfg_wdata;
        REG_OFFSET:   brake_offset    <= cfg_wdata;
        REG_LIMIT:    speed_limit     <= cfg_wdata;
        REG_CAP:      brake_cap       <= cfg_wdata;
        REG_CRUISE:   cruise_speed    <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      prev_rel_x   <= '0;
      prev_rel_y   <= '0;
      last_speed   <= '0;
      origin_taken <= 1'b0;
      stop_latched <= 1'b0;
    end else begin
      if (accept && !origin_taken) begin
        origin_x     <= s_tdata[31:0];
        origin_y     <= s_tdata[63:32];
        origin_taken <= 1'b1;
      end
      if (state == S_SPD) begin
        last_speed <= spd_sat;
        prev_rel_x <= rel_x;
        prev_rel_y <= rel_y;
      end
      if (state == S_STOP && stop_hit) begin
        stop_latched <= 1'b1;
      end
    end
  end

  // working registers (payload, no reset)
  always_ff @(posedge clk) begin
    if (accept) begin
      is_origin <= !origin_taken;
      rel_x     <= origin_taken ? (s_tdata[31:0] - origin_x) : '0;
      rel_y     <= origin_taken ? (s_tdata[63:32] - origin_y) : '0;
    end
    unique case (state)
      S_DX:    ay_mag     <= ay_full;
      S_DY:    sq_a       <= prod;
      S_BRK:   brake_dist <= brake_cap;   // kept only when over the limit
      S_T1L:   sq_hi      <= prod[63:48];
      S_T1H:   pl         <= prod[PROD_W-1:16];
      S_LIN:   t1         <= (t1_sum[64:32] != '0) ? U32_MAX : t1_sum[31:0];
      S_SUM:   brake_dist <= (dist_sum[33:32] != '0) ? U32_MAX : dist_sum[31:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_word.rel_x            <= rel_x;
      out_word.rel_y            <= rel_y;
      out_word.speed            <= last_speed;
      out_word.braking_distance <= brake_dist;
      out_word.drive_command    <= stop_latched ? '0 : cruise_speed;
      out_word.stopped          <= stop_latched;
      out_word.origin_sample    <= is_origin;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'b0, out_word.stopped, out_word.drive_command,
                     out_word.braking_distance, out_word.speed,
                     out_word.rel_y, out_word.rel_x};
  assign m_tuser  = out_word.origin_sample;

  // checks
  `OBSC_ASSERT_NEXT(a_stop_sticky, clk, rst, stop_latched, stop_latched)
  `OBSC_ASSERT(a_stopped_no_drive, clk, rst, m_tvalid && out_word.stopped,
               out_word.drive_command == '0)
  `OBSC_ASSERT(a_origin_rel_zero, clk, rst, m_tvalid && out_word.origin_sample,
               (out_word.rel_x == '0) && (out_word.rel_y == '0))
  `OBSC_ASSERT_NEXT(a_one_word_at_a_time, clk, rst, accept, !s_tready)

endmodule

### sim/obsc_stop_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the odometry braking stop controller: mirrors origin, speed,
// braking and stop latch, and checks each result word in order.
// Depends on obsc_pkg.
module obsc_stop_checker
  import obsc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // pose_x[31:0], pose_y[63:32]
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  // rel_x, rel_y, speed, braking_distance, drive_command, stopped, pad
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  input  logic                   m_tuser,   // origin_sample[0]
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_addr,
  input  logic [DATA_W-1:0]      cfg_wdata,
  output int                     mismatch_count,
  output int                     results_owed
);

  // register copies
  logic [31:0] goal_dist, coef_sq, coef_lin, brake_const, slow_limit, capped_dist;
  logic [31:0] cruise;
  logic [7:0]  rate;

  // odometry state
  logic [31:0] origin_x, origin_y, prev_rx, prev_ry, last_speed;
  logic        origin_taken, stop_latched;

  result_t     owed_results[$];

  function automatic logic [31:0] clip32(input logic [95:0] v);
    return (v > 96'hFFFF_FFFF) ? '1 : v[31:0];
  endfunction

  // floor square root, one root bit per pair of radicand bits
  function automatic logic [32:0] isqrt66(input logic [65:0] rad);
    logic [67:0] rem;
    logic [67:0] trial;
    logic [32:0] root;
    int          i;
    rem  = '0;
    root = '0;
    for (i = 32; i >= 0; i--) begin
      rem   = {rem[65:0], rad[2*i +: 2]};
      trial = {33'b0, root, 2'b01};
      if (rem >= trial) begin
        rem  = rem - trial;
        root = {root[31:0], 1'b1};
      end else begin
        root = {root[31:0], 1'b0};
      end
    end
    return root;
  endfunction

  function automatic logic [31:0] braking_for_speed(input logic [31:0] v);
    logic [63:0] vsq;
    logic [31:0] t1, t2;
    if (v > slow_limit) return capped_dist;
    vsq = (64'(v) * 64'(v)) >> 16;
    t1  = clip32((96'(coef_sq) * 96'(vsq)) >> 16);
    t2  = clip32((96'(coef_lin) * 96'(v)) >> 16);
    return clip32(96'(t1) + 96'(t2) + 96'(brake_const));
  endfunction

  task automatic advance_odometry(input logic [63:0] pose, output result_t r);
    logic [31:0]        px, py, rx, ry, ax, ay, brk;
    logic signed [32:0] dx, dy;
    logic [65:0]        rad;
    logic               first;
    px    = pose[31:0];
    py    = pose[63:32];
    rx    = '0;
    ry    = '0;
    first = !origin_taken;
    if (first) begin
      origin_x     = px;
      origin_y     = py;
      origin_taken = 1'b1;
    end else begin
      rx  = px - origin_x;
      ry  = py - origin_y;
      dx  = $signed({rx[31], rx}) - $signed({prev_rx[31], prev_rx});
      dy  = $signed({ry[31], ry}) - $signed({prev_ry[31], prev_ry});
      ax  = dx[32] ? 32'(-dx) : dx[31:0];
      ay  = dy[32] ? 32'(-dy) : dy[31:0];
      rad = 66'(64'(ax) * 64'(ax)) + 66'(64'(ay) * 64'(ay));
      last_speed = clip32(96'(isqrt66(rad)) * 96'(rate));
      prev_rx = rx;
      prev_ry = ry;
    end
    brk = braking_for_speed(last_speed);
    if (!stop_latched && ($signed({{2{rx[31]}}, rx}) + $signed({2'b00, brk})
                          >= $signed({2'b00, goal_dist})))
      stop_latched = 1'b1;
    r.rel_x            = rx;
    r.rel_y            = ry;
    r.speed            = last_speed;
    r.braking_distance = brk;
    r.drive_command    = stop_latched ? '0 : cruise;
    r.stopped          = stop_latched;
    r.origin_sample    = first;
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("obsc: %s mismatch, got %h want %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic check_word(input result_t want);
    if (m_tdata[31:0] !== want.rel_x)
      flag_mismatch("rel_x", m_tdata[31:0], want.rel_x);
    if (m_tdata[63:32] !== want.rel_y)
      flag_mismatch("rel_y", m_tdata[63:32], want.rel_y);
    if (m_tdata[95:64] !== want.speed)
      flag_mismatch("speed", m_tdata[95:64], want.speed);
    if (m_tdata[127:96] !== want.braking_distance)
      flag_mismatch("braking_distance", m_tdata[127:96], want.braking_distance);
    if (m_tdata[159:128] !== want.drive_command)
      flag_mismatch("drive_command", m_tdata[159:128], want.drive_command);
    if (m_tdata[160] !== want.stopped)
      flag_mismatch("stopped", 32'(m_tdata[160]), 32'(want.stopped));
    if (m_tdata[167:161] !== '0)
      flag_mismatch("pad", 32'(m_tdata[167:161]), '0);
    if (m_tuser !== want.origin_sample)
      flag_mismatch("origin_sample", 32'(m_tuser), 32'(want.origin_sample));
  endtask

  initial mismatch_count = 0;

  always @(posedge clk) begin
    result_t r;
    if (rst) begin
      goal_dist    = RST_TARGET;
      rate         = RST_RATE;
      coef_sq      = RST_COEF_SQ;
      coef_lin     = RST_COEF_LIN;
      brake_const  = RST_OFFSET;
      slow_limit   = RST_LIMIT;
      capped_dist  = RST_CAP;
      cruise       = RST_CRUISE;
      origin_x     = '0;
      origin_y     = '0;
      prev_rx      = '0;
      prev_ry      = '0;
      last_speed   = '0;
      origin_taken = 1'b0;
      stop_latched = 1'b0;
      owed_results.delete();
    end else begin
      // retire before accepting: a word taken this edge cannot answer itself
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0)
          flag_mismatch("unexpected word, rel_x", m_tdata[31:0], '0);
        else
          check_word(owed_results.pop_front());
      end
      if (s_tvalid && s_tready) begin
        advance_odometry(s_tdata, r);
        owed_results.push_back(r);
      end
      if (cfg_we) begin
        case (cfg_addr)
          REG_TARGET:   goal_dist   = cfg_wdata;
          REG_RATE:     rate        = cfg_wdata[7:0];
          REG_COEF_SQ:  coef_sq     = cfg_wdata;
          REG_COEF_LIN: coef_lin    = cfg_wdata;
          REG_OFFSET:   brake_const = cfg_wdata;
          REG_LIMIT:    slow_limit  = cfg_wdata;
          REG_CAP:      capped_dist = cfg_wdata;
          REG_CRUISE:   cruise      = cfg_wdata;
          default:      ;
        endcase
      end
    end
    results_owed <= owed_results.size();
  end

endmodule

### sim/tb_odometry_braking_stop_controller_core.sv
`timescale 1ns / 1ps
// Testbench top for the odometry braking stop controller: clock, reset,
// pose stimulus, config phases and verdict. Depends on obsc_pkg, the core
// and obsc_stop_checker.
module tb_odometry_braking_stop_controller_core
  import obsc_pkg::*;
();

  typedef struct packed {
    logic [31:0] goal;
    logic [7:0]  rate;
    logic [31:0] coef_sq;
    logic [31:0] coef_lin;
    logic [31:0] offset;
    logic [31:0] limit;
    logic [31:0] cap;
    logic [31:0] cruise;
  } brake_cfg_t;

  // size of a random move on one axis
  typedef enum logic [1:0] {
    STRIDE_TINY,
    STRIDE_METRE,
    STRIDE_WILD,
    STRIDE_STILL
  } stride_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;   // pose_x[31:0], pose_y[63:32]
  logic                   m_tready  = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [2:0]             cfg_addr  = '0;
  logic [DATA_W-1:0]      cfg_wdata = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  // rel_x[31:0], rel_y[63:32], speed[95:64], braking_distance[127:96],
  // drive_command[159:128], stopped[160], zero pad [167:161]
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;          // origin_sample[0]

  int          mismatch_count;
  int          results_owed;
  bit          calm      = 1'b0;   // no idling on either side
  int          hold_asks = 0;      // long sink hold-offs requested
  logic [31:0] home_x, home_y;     // pose taken as origin
  logic [31:0] at_x, at_y;         // last relative position sent

  always #2 clk = ~clk;

  odometry_braking_stop_controller_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  obsc_stop_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // Result sink. Drops tready about 37% of cycles; a hold-off request holds
  // it low so the core backs up and drops s_tready.
  initial begin : sink
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left   = 400;
      end
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (calm) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= 37);
      end
    end
  end

  // Hard stop: the run fails if it has not finished by then.
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Sender gaps: mostly short geometric runs, now and then a long one so
  // the next word lands on any phase of the root and multiply passes.
  task automatic idle_sender();
    int gap;
    gap = 0;
    if (!calm) begin
      if ($urandom_range(7) == 0)
        gap = $urandom_range(1, 50);
      else
        while ($urandom_range(99) < 37) gap++;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // valid stays high after the handshake; the next call lowers or reloads it
  task automatic send_pose(input logic [31:0] x, input logic [31:0] y);
    idle_sender();
    s_tvalid <= 1'b1;
    s_tdata  <= {y, x};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_rel(input logic [31:0] rx, input logic [31:0] ry);
    at_x = rx;
    at_y = ry;
    send_pose(home_x + rx, home_y + ry);
  endtask

  // pause until every word in flight has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // cfg_we is left high between writes and lowered once at the end
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= v;
    @(posedge clk);
  endtask

  task automatic apply_settings(input brake_cfg_t c);
    write_reg(REG_TARGET, c.goal);
    write_reg(REG_RATE, 32'(c.rate));
    write_reg(REG_COEF_SQ, c.coef_sq);
    write_reg(REG_COEF_LIN, c.coef_lin);
    write_reg(REG_OFFSET, c.offset);
    write_reg(REG_LIMIT, c.limit);
    write_reg(REG_CAP, c.cap);
    write_reg(REG_CRUISE, c.cruise);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] any_scale();
    return $urandom >> $urandom_range(31);
  endfunction

  // Goal stays at its maximum so nothing stops before the final phase.
  // Bounded sets keep braking distance under 2^30, so rel_x may take any
  // value; the others can saturate and must be paired with rel_x < 0.
  function automatic brake_cfg_t roll_settings(input bit bounded);
    brake_cfg_t c;
    c.goal   = 32'hFFFF_FFFF;
    c.rate   = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 3))
                                        : 8'($urandom_range(1, 255));
    c.cruise = $urandom;
    if (bounded) begin
      c.coef_sq  = $urandom & 32'h0000_FFFF;
      c.coef_lin = $urandom & 32'h0000_FFFF;
      c.offset   = $urandom & 32'h00FF_FFFF;
      c.limit    = $urandom & 32'h000F_FFFF;
      c.cap      = $urandom & 32'h3FFF_FFFF;
    end else begin
      c.coef_sq  = any_scale();
      c.coef_lin = any_scale();
      c.offset   = any_scale();
      c.limit    = any_scale();
      c.cap      = $urandom;
    end
    return c;
  endfunction

  function automatic logic [31:0] stride(input stride_t k);
    case (k)
      STRIDE_TINY:  return 32'($urandom_range(2047)) - 32'd1024;
      STRIDE_METRE: return ($urandom & 32'h0003_FFFF) - 32'h0002_0000;
      STRIDE_WILD:  return $urandom;
      default:      return '0;
    endcase
  endfunction

  // random walk in relative space; neg_only folds a non-negative x below zero
  task automatic wander(input bit neg_only);
    logic [31:0] nx, ny;
    nx = at_x + stride(stride_t'($urandom_range(3)));
    ny = at_y + stride(stride_t'($urandom_range(3)));
    if (neg_only && !nx[31]) nx = ~nx;
    send_rel(nx, ny);
  endtask

  initial begin : stimulus
    brake_cfg_t c;
    int         ph, n;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults. x stays well behind the goal (at least 2 m) so the latch
    // cannot trip on the 1.15 m cap.
    home_x = 32'h8000_0000;
    home_y = 32'h7FFF_FFFF;
    at_x   = '0;
    at_y   = '0;
    send_pose(home_x, home_y);                    // origin: zeros, speed held
    send_rel(32'hFFFD_0000, 32'h0000_8000);       // first step measured from (0,0)
    send_rel(32'hFFFD_028F, 32'h0000_8000);       // 1 cm step, quadratic branch
    send_rel(32'hFFFD_028F, 32'h0000_8000);       // no movement
    send_rel(32'h8000_0000, 32'h7FFF_FFFF);       // relative extremes
    send_rel(32'h8000_0000, 32'h8000_0000);       // full-width y step
    send_rel(32'hFFFE_0000, 32'h0000_0000);
    send_rel(32'hFFFE_1333, 32'h0000_0000);       // just under the speed limit
    send_rel(32'hFFFE_2667, 32'h0000_0000);       // just over it

    // Everything at its top except the cap: terms and sum saturate.
    drain();
    c = '{32'hFFFF_FFFF, 8'd255, '1, '1, '1, '1, 32'h0, '1};
    apply_settings(c);
    send_rel(32'hFFFF_FFFF, 32'h8000_0000);
    send_rel(32'hFFFF_FFFF, 32'h7FFF_FFFF);       // speed saturates, v^2 term huge
    send_rel(32'hFFFF_FFFF, 32'h7FFF_FFFF);       // zero speed: offset alone
    send_rel(32'hFFFF_FFFE, 32'h7FFF_FFFF);       // one-lsb step

    // Unit rate, zero coefficients, limit zero: widest diagonal step.
    drain();
    c = '{32'hFFFF_FFFF, 8'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0};
    apply_settings(c);
    send_rel(32'h8000_0000, 32'h8000_0000);
    send_rel(32'h7FFF_FFFF, 32'h7FFF_FFFF);       // radicand past 2^64
    send_rel(32'h8000_0000, 32'h8000_0000);
    send_rel(32'h8000_0000, 32'h8000_0000);       // speed zero equals the limit

    // Speed exactly at, above and below the limit.
    drain();
    c = '{32'hFFFF_FFFF, 8'd1, 32'h0002_0000, 32'h0000_8000, 32'd5,
          32'h0001_0000, 32'h00AB_CDEF, 32'h1234_5678};
    apply_settings(c);
    send_rel(32'hFFF6_0000, 32'h0000_0000);
    send_rel(32'hFFF7_0000, 32'h0000_0000);
    send_rel(32'hFFF8_0001, 32'h0000_0000);
    send_rel(32'hFFF9_0000, 32'h0000_0000);

    // Zero sample rate: speed is always zero.
    drain();
    c = '{32'hFFFF_FFFF, 8'd0, $urandom, $urandom, 32'h0001_2345, 32'h0,
          32'h4000_0000, $urandom};
    apply_settings(c);
    wander(1'b1);
    wander(1'b1);

    // Random phases: bounded braking with free x, then saturating braking
    // with x behind the origin. Phase 2 holds the sink off mid-stream;
    // phase 3 runs with no idling at all.
    for (ph = 1; ph <= 6; ph++) begin
      drain();
      apply_settings(roll_settings(ph % 2 == 1));
      calm = (ph == 3);
      for (n = 0; n < 135; n++) begin
        if (ph == 2 && n == 40) hold_asks++;
        wander(ph % 2 == 0);
      end
    end
    calm = 1'b0;

    // Stop phase: braking is the offset alone, so the latch trips exactly
    // when rel_x reaches goal - offset. Then stopped words for a while.
    drain();
    c = '{32'h0010_0000, 8'($urandom_range(1, 255)), 32'h0, 32'h0, 32'h0000_0100,
          32'hFFFF_FFFF, $urandom, $urandom};
    apply_settings(c);
    send_rel(32'hFFF0_0000, at_y);
    send_rel(32'h000F_FEFF, at_y);                // one lsb short of the goal
    send_rel(32'h000F_FF00, at_y);                // meets it: latched
    for (n = 0; n < 40; n++) wander(1'b0);

    drain();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
